// File: hdl/utf8d_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 stream decoder.
// Used by the front, queue, back and top-level modules; no dependencies.
package utf8d_pkg;

	// Code point limits and markers.
	localparam logic [20:0] REPL_CHAR  = 21'h00FFFD;
	localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;
	localparam logic [20:0] MIN_LEN1   = 21'h000080;
	localparam logic [20:0] MIN_LEN2   = 21'd2048;
	localparam logic [20:0] MIN_LEN3   = 21'd65536;

	// Byte classification bounds.
	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD_END = 8'hF5;
	localparam logic [7:0] ASCII_END = 8'h80;
	localparam logic [1:0] CONT_TAG = 2'b10;

	// Depth of the queue between the front and back parts.
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// One queued entry: the results caused by one input item.
	typedef struct packed {
		logic        two;
		logic [20:0] cp_first;
		logic [20:0] cp_last;
	} entry_t;

endpackage

// File: hdl/utf8_stream_decoder_top.sv
`timescale 1ns / 1ps
// UTF-8 stream decoder: one byte in, zero to two code points out.
// Results are registered in the queue and shown in order as older ones are popped.
// Throughput: one byte per cycle unless the queue is full, set by the classify step
// in the front; a byte giving two results holds its queue slot for two pops.
// Reset (arst_n low, asynchronous): closes any open sequence and empties the queue.
module utf8_stream_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  byte_in,
	output logic        empty,
	input  logic        pop,
	output logic [20:0] code_point,
	output logic        last_of_run
);
	import utf8d_pkg::*;

	logic   q_wr;
	logic   q_rd;
	logic   q_empty;
	entry_t wr_entry;
	entry_t rd_entry;

	// Byte classification and sequence tracking.
	utf8d_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.byte_in (byte_in),
		.q_full  (full),
		.q_wr    (q_wr),
		.q_entry (wr_entry)
	);

	// Decoupling queue.
	utf8d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_entry (wr_entry),
		.rd       (q_rd),
		.rd_entry (rd_entry),
		.full     (full),
		.empty    (q_empty)
	);

	// Result delivery.
	utf8d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_entry     (rd_entry),
		.q_empty     (q_empty),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.code_point  (code_point),
		.last_of_run (last_of_run)
	);

endmodule

// File: hdl/utf8d_front.sv
`timescale 1ns / 1ps
// Front part: accepts bytes, tracks the open sequence and builds one
// queue entry per item that causes results. Depends on utf8d_pkg.
module utf8d_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [7:0]             byte_in,
	input  logic                   q_full,
	output logic                   q_wr,
	output utf8d_pkg::entry_t      q_entry
);
	import utf8d_pkg::*;

	logic [1:0]  pending_q;
	logic [1:0]  seqlen_q;
	logic [20:0] partial_q;

	logic [1:0]  pending_d;
	logic [1:0]  seqlen_d;
	logic [20:0] partial_d;

	logic        accept;
	logic        is_cont;
	logic        lead_res;
	logic [20:0] lead_cp;
	logic [1:0]  lead_len;
	logic [20:0] lead_part;
	logic [20:0] shifted;
	logic [20:0] finished;
	logic        emit;
	logic        bad;

	assign accept  = push && !q_full;
	assign is_cont = (byte_in[7:6] == CONT_TAG);
	assign shifted = {partial_q[14:0], byte_in[5:0]};

	// Classify a byte handled as a lead.
	always_comb begin
		lead_res  = 1'b0;
		lead_cp   = REPL_CHAR;
		lead_len  = 2'd0;
		lead_part = '0;
		if (byte_in < ASCII_END) begin
			lead_res = 1'b1;
			lead_cp  = {13'd0, byte_in};
		end else if (byte_in >= LEAD2_LO && byte_in < LEAD3_LO) begin
			lead_len  = 2'd1;
			lead_part = {16'd0, byte_in[4:0]};
		end else if (byte_in >= LEAD3_LO && byte_in < LEAD4_LO) begin
			lead_len  = 2'd2;
			lead_part = {17'd0, byte_in[3:0]};
		end else if (byte_in >= LEAD4_LO && byte_in < LEAD_END) begin
			lead_len  = 2'd3;
			lead_part = {18'd0, byte_in[2:0]};
		end else begin
			lead_res = 1'b1;
		end
	end

	// Validate a sequence completed by this continuation byte.
	always_comb begin
		bad = (shifted > MAX_SCALAR) || (shifted >= SURR_LO && shifted <= SURR_HI);
		case (seqlen_q)
			2'd1:    bad = bad || (shifted < MIN_LEN1);
			2'd2:    bad = bad || (shifted < MIN_LEN2);
			2'd3:    bad = bad || (shifted < MIN_LEN3);
			default: bad = bad;
		endcase
		finished = bad ? REPL_CHAR : shifted;
	end

	// Next sequence state and the entry for this item.
	always_comb begin
		pending_d        = pending_q;
		seqlen_d         = seqlen_q;
		partial_d        = partial_q;
		emit             = 1'b0;
		q_entry.two      = 1'b0;
		q_entry.cp_first = REPL_CHAR;
		q_entry.cp_last  = REPL_CHAR;
		if (pending_q != 2'd0) begin
			if (is_cont) begin
				pending_d = pending_q - 2'd1;
				partial_d = shifted;
				if (pending_q == 2'd1) begin
					emit            = 1'b1;
					q_entry.cp_last = finished;
					seqlen_d        = 2'd0;
					partial_d       = '0;
				end
			end else begin
				// Cut sequence: replacement first, then the byte as a lead.
				emit             = 1'b1;
				q_entry.two      = lead_res;
				q_entry.cp_first = REPL_CHAR;
				q_entry.cp_last  = lead_res ? lead_cp : REPL_CHAR;
				pending_d        = lead_len;
				seqlen_d         = lead_len;
				partial_d        = lead_part;
			end
		end else begin
			emit            = lead_res;
			q_entry.cp_last = lead_cp;
			pending_d       = lead_len;
			seqlen_d        = lead_len;
			partial_d       = lead_part;
		end
	end

	assign q_wr = accept && emit;

	// Sequence state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			seqlen_q  <= 2'd0;
			partial_q <= '0;
		end else if (accept) begin
			pending_q <= pending_d;
			seqlen_q  <= seqlen_d;
			partial_q <= partial_d;
		end
	end

endmodule

// File: hdl/utf8d_queue.sv
`timescale 1ns / 1ps
// Short queue of decoded entries between the front and back parts.
// Depends on utf8d_pkg for the entry type and depth.
module utf8d_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr,
	input  utf8d_pkg::entry_t      wr_entry,
	input  logic                   rd,
	output utf8d_pkg::entry_t      rd_entry,
	output logic                   full,
	output logic                   empty
);
	import utf8d_pkg::*;

	entry_t                store_q [QDEPTH];
	logic [QPTR_W-1:0]     wptr_q;
	logic [QPTR_W-1:0]     rptr_q;
	logic [QCNT_W-1:0]     count_q;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = store_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr) begin
			store_q[wptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/utf8d_back.sv
`timescale 1ns / 1ps
// Back part: unpacks queued entries into single results, the first of a
// pair before the last. Depends on utf8d_pkg for the entry type.
module utf8d_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  utf8d_pkg::entry_t      q_entry,
	input  logic                   q_empty,
	output logic                   q_rd,
	input  logic                   pop,
	output logic                   empty,
	output logic [20:0]            code_point,
	output logic                   last_of_run
);
	import utf8d_pkg::*;

	logic second_q;
	logic show_first;
	logic take;

	assign empty       = q_empty;
	assign show_first  = q_entry.two && !second_q;
	assign code_point  = show_first ? q_entry.cp_first : q_entry.cp_last;
	assign last_of_run = !show_first;
	assign take        = pop && !q_empty;
	assign q_rd        = take && !show_first;

	// Tracks whether the first result of a pair has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
		end else if (take) begin
			second_q <= show_first;
		end
	end

endmodule

// File: bench/utf8_stream_decoder_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the UTF-8 stream decoder: watches both queue-style channels,
// predicts the code points of every accepted byte and compares them in order.
// Depends on utf8d_pkg for the code point limits and byte class bounds.
module utf8_stream_decoder_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  byte_in,
	input  logic        empty,
	input  logic        pop,
	input  logic [20:0] code_point,
	input  logic        last_of_run,
	output int          fail_count,
	output int          pending,
	output int          items_seen,
	output int          results_seen,
	output int          repl_seen,
	output int          pairs_seen
);
	import utf8d_pkg::*;

	// One expected result: the code point and its end-of-item flag.
	typedef struct packed {
		logic [20:0] cp;
		logic        last;
	} decoded_t;

	decoded_t expected_points [$];

	// Decoder state as the prediction sees it.
	logic [1:0]  cont_left;
	logic [1:0]  seq_len;
	logic [20:0] gathered;

	initial begin
		fail_count   = 0;
		pending      = 0;
		items_seen   = 0;
		results_seen = 0;
		repl_seen    = 0;
		pairs_seen   = 0;
	end

	// A finished sequence is only a scalar if it is minimal, outside the
	// surrogate range and within the Unicode range.
	function automatic logic [20:0] checked_scalar(input logic [1:0] len,
			input logic [20:0] c);
		if ((len == 2'd1 && c < MIN_LEN1) || (len == 2'd2 && c < MIN_LEN2) ||
				(len == 2'd3 && c < MIN_LEN3) || c > MAX_SCALAR ||
				(c >= SURR_LO && c <= SURR_HI))
			return REPL_CHAR;
		return c;
	endfunction

	// Work out the code points one accepted byte causes and queue them.
	task automatic decode_byte(input logic [7:0] b);
		decoded_t found [2];
		int       n;
		logic     as_lead;
		n = 0;
		as_lead = 1'b1;
		if (cont_left != 2'd0) begin
			if (b[7:6] == CONT_TAG) begin
				as_lead = 1'b0;
				gathered = {gathered[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 2'd0) begin
					found[0].cp = checked_scalar(seq_len, gathered);
					n = 1;
					seq_len = 2'd0;
					gathered = '0;
				end
			end else begin
				// The open sequence is cut: replace it, then treat the byte as new.
				found[0].cp = REPL_CHAR;
				n = 1;
				cont_left = 2'd0;
				seq_len = 2'd0;
				gathered = '0;
			end
		end
		if (as_lead) begin
			if (b < ASCII_END) begin
				found[n].cp = {13'd0, b};
				n++;
			end else if (b >= LEAD2_LO && b < LEAD3_LO) begin
				gathered = {16'd0, b[4:0]};
				seq_len = 2'd1;
			end else if (b >= LEAD3_LO && b < LEAD4_LO) begin
				gathered = {17'd0, b[3:0]};
				seq_len = 2'd2;
			end else if (b >= LEAD4_LO && b < LEAD_END) begin
				gathered = {18'd0, b[2:0]};
				seq_len = 2'd3;
			end else begin
				found[n].cp = REPL_CHAR;
				n++;
			end
			cont_left = seq_len;
		end
		for (int i = 0; i < n; i++) begin
			found[i].last = (i == n - 1);
			expected_points.push_back(found[i]);
		end
		items_seen++;
		if (n == 2)
			pairs_seen++;
	endtask

	task automatic report_mismatch(input string what, input logic [20:0] want,
			input logic [20:0] got);
		$display("mismatch on %s at result %0d: expected %h, got %h",
			what, results_seen, want, got);
		fail_count++;
	endtask

	// Compare one popped result with the oldest prediction.
	task automatic check_result();
		decoded_t want;
		if (expected_points.size() == 0) begin
			report_mismatch("result with no byte behind it", '0, code_point);
		end else begin
			want = expected_points.pop_front();
			if (code_point !== want.cp)
				report_mismatch("code_point", want.cp, code_point);
			if (last_of_run !== want.last)
				report_mismatch("last_of_run", {20'd0, want.last}, {20'd0, last_of_run});
		end
		results_seen++;
		if (code_point == REPL_CHAR)
			repl_seen++;
	endtask

	// Results are checked before the byte of the same edge is predicted; a byte
	// cannot show its result in the cycle it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_left = 2'd0;
			seq_len = 2'd0;
			gathered = '0;
			expected_points.delete();
			pending = 0;
		end else begin
			if (pop && !empty)
				check_result();
			if (push && !full)
				decode_byte(byte_in);
			pending = expected_points.size();
		end
	end

endmodule

// File: bench/utf8_stream_decoder_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the UTF-8 stream decoder: clock, reset, byte stimulus,
// result draining and the verdict. Depends on utf8d_pkg and the checker module.
module utf8_stream_decoder_top_tb;
	import utf8d_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BYTES = 1500;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  byte_in;
	logic        empty;
	logic        pop;
	logic [20:0] code_point;
	logic        last_of_run;

	int   fail_count;
	int   pending;
	int   items_seen;
	int   results_seen;
	int   repl_seen;
	int   pairs_seen;
	int   sent;
	int   cycles;
	logic calm;
	logic [7:0] directed [$];

	utf8_stream_decoder_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.byte_in     (byte_in),
		.empty       (empty),
		.pop         (pop),
		.code_point  (code_point),
		.last_of_run (last_of_run)
	);

	utf8_stream_decoder_checker decode_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.byte_in      (byte_in),
		.empty        (empty),
		.pop          (pop),
		.code_point   (code_point),
		.last_of_run  (last_of_run),
		.fail_count   (fail_count),
		.pending      (pending),
		.items_seen   (items_seen),
		.results_seen (results_seen),
		.repl_seen    (repl_seen),
		.pairs_seen   (pairs_seen)
	);

	// 8 ns clock.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog on the whole run.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Result side: pop stays high except for random stalls.
	initial begin
		int hold;
		hold = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				pop <= 1'b0;
				hold--;
			end else begin
				pop <= 1'b1;
				hold = calm ? 0 : pick_gap();
			end
		end
	end

	// Offer one byte, optionally after a gap, and return at the falling edge
	// after it has been taken. Push is left high for a back-to-back item.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			byte_in <= 8'($urandom_range(0, 255));
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		byte_in <= b;
		while (full)
			@(negedge clk);
		@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// Encode a value the standard way; values past the Unicode range and
	// surrogates go through too, so the block has to reject them.
	task automatic send_scalar(input logic [20:0] cp);
		if (cp < 21'h80) begin
			send_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			send_byte({3'b110, cp[10:6]});
			send_byte({CONT_TAG, cp[5:0]});
		end else if (cp < 21'h10000) begin
			send_byte({4'b1110, cp[15:12]});
			send_byte({CONT_TAG, cp[11:6]});
			send_byte({CONT_TAG, cp[5:0]});
		end else begin
			send_byte({5'b11110, cp[20:18]});
			send_byte({CONT_TAG, cp[17:12]});
			send_byte({CONT_TAG, cp[11:6]});
			send_byte({CONT_TAG, cp[5:0]});
		end
	endtask

	// Lead byte of a sequence with the given number of continuation bytes.
	task automatic send_lead(input int len);
		logic [7:0] b;
		if (len == 1)
			b = 8'($urandom_range(LEAD2_LO, LEAD3_LO - 1));
		else if (len == 2)
			b = 8'($urandom_range(LEAD3_LO, LEAD4_LO - 1));
		else
			b = 8'($urandom_range(LEAD4_LO, LEAD_END - 1));
		send_byte(b);
	endtask

	task automatic send_tail(input int count);
		for (int i = 0; i < count; i++)
			send_byte({CONT_TAG, 6'($urandom_range(0, 63))});
	endtask

	// Values near the class and range boundaries, else random within a class.
	function automatic logic [20:0] pick_scalar();
		if ($urandom_range(0, 9) < 2) begin
			case ($urandom_range(0, 13))
				0:       return 21'h00007F;
				1:       return 21'h000080;
				2:       return 21'h0007FF;
				3:       return 21'h000800;
				4:       return 21'h00D7FF;
				5:       return SURR_LO;
				6:       return SURR_HI;
				7:       return 21'h00E000;
				8:       return REPL_CHAR;
				9:       return 21'h00FFFF;
				10:      return 21'h010000;
				11:      return MAX_SCALAR;
				12:      return 21'h110000;
				default: return 21'h13FFFF;
			endcase
		end
		case ($urandom_range(0, 3))
			0:       return 21'($urandom_range(0, 21'h7F));
			1:       return 21'($urandom_range(21'h80, 21'h7FF));
			2:       return 21'($urandom_range(21'h800, 21'hFFFF));
			default: return 21'($urandom_range(21'h10000, 21'h10FFFF));
		endcase
	endfunction

	// A byte that cannot continue a sequence, sometimes the terminator.
	function automatic logic [7:0] cut_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b[7:6] == CONT_TAG)
			b[6] = 1'b1;
		if ($urandom_range(0, 4) == 0)
			b = 8'h00;
		return b;
	endfunction

	initial begin
		int kind;
		int len;
		int first_random;
		arst_n = 1'b0;
		push = 1'b0;
		byte_in = 8'h00;
		calm = 1'b0;
		sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed bytes: ASCII top, stray continuation, invalid leads, the
		// smallest and largest two-byte values, an overlong, a surrogate, a value
		// past the range, a valid four-byte value, and sequences cut by ASCII,
		// by a new lead and by the terminator.
		directed = {8'h7F, 8'h80, 8'hC0, 8'hFF, 8'hC2, 8'h80, 8'hDF, 8'hBF,
			8'hE0, 8'h80, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
			8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2, 8'h41, 8'hC3, 8'hE2, 8'h00};
		foreach (directed[i])
			send_byte(directed[i]);

		// Random part: mostly complete sequences with random content, the rest
		// cut sequences and raw noise.
		first_random = sent;
		while (sent < first_random + RANDOM_BYTES) begin
			calm = ($urandom_range(0, 7) == 0);
			kind = $urandom_range(0, 99);
			len = $urandom_range(1, 3);
			if (kind < 35) begin
				send_scalar(pick_scalar());
			end else if (kind < 60) begin
				send_lead(len);
				send_tail(len);
			end else if (kind < 72) begin
				send_lead(len);
				send_tail($urandom_range(0, len - 1));
				send_byte(cut_byte());
			end else if (kind < 88) begin
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				send_byte(8'($urandom_range(0, 127)));
			end
		end
		push <= 1'b0;
		calm = 1'b0;

		// Drain what is still expected, then allow a few more cycles.
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Sent %0d bytes; %0d code points checked, %0d of them U+FFFD.",
			items_seen, results_seen, repl_seen);
		$display("%0d bytes caused two code points; %0d mismatches.", pairs_seen, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
